// File: hdl/btl_pkg.sv
// Shared types and constants for the bounding-box target locator.
package btl_pkg;

    localparam int COORD_BITS  = 12;
    localparam int PROB_W      = 16;
    localparam int HS_W        = 12;
    localparam int RC_W        = 16;
    localparam int IDX_W       = 8;
    localparam int OFS_W       = 16;
    localparam int RNG_W       = 24;

    localparam int MAX_BOXES_DEF   = 256;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [HS_W-1:0] HS_RESET = HS_W'(208);
    localparam logic [RC_W-1:0] RC_RESET = RC_W'(5 * 117);

    // squared diagonal, range numerator and its square
    localparam int D2_W      = 2 * COORD_BITS + 1;
    localparam int NUM_BASE  = RC_W + 8;
    localparam int DIV_NUM_W = 2 * NUM_BASE;
    localparam int DIV_DEN_W = D2_W;
    localparam int ROOT_W    = DIV_NUM_W / 2;

    localparam logic [RNG_W-1:0] RANGE_MAX = {RNG_W{1'b1}};

    // register indexes on the configuration port
    localparam logic REG_HALF_SIZE = 1'b0;
    localparam logic REG_RANGE_K   = 1'b1;

    typedef struct packed {
        logic                  detected;
        logic [IDX_W-1:0]      slot;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] bottom;
    } btl_job_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } btl_div_req_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] value;
    } btl_sqrt_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } btl_unit_sts_t;

endpackage

// File: hdl/btl_front.sv
// Front end: per-frame argmax over incoming boxes, emits one job per frame.
module btl_front
    import btl_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  box_valid,
    input  logic [COORD_BITS-1:0] box_xmin,
    input  logic [COORD_BITS-1:0] box_xmax,
    input  logic [COORD_BITS-1:0] box_ymin,
    input  logic [COORD_BITS-1:0] box_ymax,
    input  logic [PROB_W-1:0]     probability,
    input  logic                  last_box,
    output logic                  push,
    output btl_job_t              job
);

    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    logic [PROB_W-1:0]     prob_reg;
    logic [COORD_BITS-1:0] left_reg, right_reg, top_reg, bottom_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic                  counts;
    logic                  take;

    assign counts = box_valid && (cnt_reg < CNT_W'(MAX_BOXES));
    assign take   = counts && (probability > prob_reg);
    assign push   = accept && last_box;

    // job reflects the frame including the current box
    always_comb
    begin
        job.detected = take || (prob_reg != '0);
        job.slot     = take ? IDX_W'(cnt_reg) : slot_reg;
        job.left     = take ? box_xmin : left_reg;
        job.right    = take ? box_xmax : right_reg;
        job.top      = take ? box_ymin : top_reg;
        job.bottom   = take ? box_ymax : bottom_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prob_reg   <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
            top_reg    <= '0;
            bottom_reg <= '0;
            slot_reg   <= '0;
            cnt_reg    <= '0;
        end
        else if (accept)
        begin
            if (last_box)
            begin
                prob_reg   <= '0;
                left_reg   <= '0;
                right_reg  <= '0;
                top_reg    <= '0;
                bottom_reg <= '0;
                slot_reg   <= '0;
                cnt_reg    <= '0;
            end
            else
            begin
                if (take)
                begin
                    prob_reg   <= probability;
                    left_reg   <= box_xmin;
                    right_reg  <= box_xmax;
                    top_reg    <= box_ymin;
                    bottom_reg <= box_ymax;
                    slot_reg   <= IDX_W'(cnt_reg);
                end
                if (counts)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

endmodule

// File: hdl/btl_queue.sv
// Small job queue between the front end and the back end.
module btl_queue
    import btl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  btl_job_t wdata,
    output logic     full,
    output logic     nonempty,
    input  logic     pop,
    output btl_job_t rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    btl_job_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign rdata    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/btl_div.sv
// Restoring divider, one quotient bit per cycle.
module btl_div
    import btl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  btl_div_req_t         req,
    output btl_unit_sts_t        sts,
    output logic [DIV_NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg, done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg, quo_reg;
    logic [DIV_DEN_W-1:0] den_reg, rem_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 qbit;
    logic [DIV_DEN_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, num_reg[DIV_NUM_W-1]};
        qbit     = (trial >= {1'b0, den_reg});
        rem_next = qbit ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

// File: hdl/btl_isqrt.sv
// Integer square root, bit-pair method, one result bit per cycle.
module btl_isqrt
    import btl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  btl_sqrt_req_t     req,
    output btl_unit_sts_t     sts,
    output logic [ROOT_W-1:0] root
);

    logic                 busy_reg, done_reg;
    logic [DIV_NUM_W-1:0] val_reg, res_reg, bit_reg;
    logic [DIV_NUM_W-1:0] sum;
    logic                 fits;

    assign sum      = res_reg + bit_reg;
    assign fits     = (val_reg >= sum);
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign root     = res_reg[ROOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            val_reg <= req.value;
            res_reg <= '0;
            bit_reg <= DIV_NUM_W'(1) << (DIV_NUM_W - 2);
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                val_reg <= val_reg - sum;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && bit_reg[0])
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

endmodule

// File: hdl/btl_back.sv
// Back end: offsets and range of one frame's chosen box, result register.
module btl_back
    import btl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [HS_W-1:0]        image_half_size,
    input  logic [RC_W-1:0]        range_constant,
    input  logic                   job_ready,
    input  btl_job_t               job,
    output logic                   job_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   detected,
    output logic [IDX_W-1:0]       chosen_index,
    output logic signed [OFS_W-1:0] offset_x,
    output logic signed [OFS_W-1:0] offset_y,
    output logic [RNG_W-1:0]       range_estimate
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_WX   = 7'b0000100,
        S_WY   = 7'b0001000,
        S_WR   = 7'b0010000,
        S_WS   = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    localparam int SQ_W = 2 * COORD_BITS;

    state_t state_reg, state_next;

    btl_job_t              job_reg;
    logic [COORD_BITS-1:0] magx_reg, magy_reg;
    logic                  negx_reg, negy_reg;
    logic [SQ_W-1:0]       wsq_reg, hsq_reg;
    logic [DIV_NUM_W-1:0]  nsq_reg;

    logic                  det_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [OFS_W-1:0]      ox_reg, oy_reg;
    logic [RNG_W-1:0]      rng_reg;

    btl_div_req_t          div_req;
    btl_unit_sts_t         div_sts;
    logic [DIV_NUM_W-1:0]  div_quo;
    btl_sqrt_req_t         sqrt_req;
    btl_unit_sts_t         sqrt_sts;
    logic [ROOT_W-1:0]     sqrt_root;

    logic [HS_W-1:0]       h;
    logic [COORD_BITS:0]   xsum, ysum;
    logic [COORD_BITS-1:0] cx, cy;
    logic signed [COORD_BITS:0]     w, hh;
    logic signed [2*COORD_BITS+1:0] wprod, hprod;
    logic [NUM_BASE-1:0]   n;
    logic [DIV_NUM_W-1:0]  nprod;
    logic [DIV_DEN_W-1:0]  d2;

    // round-to-nearest quotient to Q1.15 with saturation
    function automatic logic [OFS_W-1:0] sat_ofs(input logic neg, input logic [DIV_NUM_W-1:0] q);
        logic [OFS_W-1:0] r;
        if (neg)
        begin
            r = (q > DIV_NUM_W'(32768)) ? 16'h8000 : OFS_W'(-q);
        end
        else
        begin
            r = (q > DIV_NUM_W'(32767)) ? 16'h7FFF : q[OFS_W-1:0];
        end
        return r;
    endfunction

    assign h    = (image_half_size == '0) ? HS_W'(1) : image_half_size;
    assign xsum = {1'b0, job.left} + {1'b0, job.right};
    assign ysum = {1'b0, job.top} + {1'b0, job.bottom};
    assign cx   = xsum[COORD_BITS:1];
    assign cy   = ysum[COORD_BITS:1];

    assign w     = $signed({1'b0, job_reg.right}) - $signed({1'b0, job_reg.left});
    assign hh    = $signed({1'b0, job_reg.bottom}) - $signed({1'b0, job_reg.top});
    assign wprod = w * w;
    assign hprod = hh * hh;
    assign n     = {range_constant, 8'h00};
    assign nprod = DIV_NUM_W'(n) * DIV_NUM_W'(n);
    assign d2    = {1'b0, wsq_reg} + {1'b0, hsq_reg};

    assign job_pop   = (state_reg == S_IDLE) && job_ready;
    assign out_valid = (state_reg == S_DONE);

    assign detected       = det_reg;
    assign chosen_index   = idx_reg;
    assign offset_x       = ox_reg;
    assign offset_y       = oy_reg;
    assign range_estimate = rng_reg;

    btl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    btl_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .sts   (sqrt_sts),
        .root  (sqrt_root)
    );

    // unit requests and next state
    always_comb
    begin
        state_next     = state_reg;
        div_req        = '0;
        sqrt_req       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_ready)
                begin
                    state_next = job.detected ? S_MUL : S_DONE;
                end
            end
            S_MUL:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'({magx_reg, 16'h0000}) + DIV_NUM_W'(h);
                div_req.den   = DIV_DEN_W'({h, 1'b0});
                state_next    = S_WX;
            end
            S_WX:
            begin
                if (div_sts.done)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_NUM_W'({magy_reg, 16'h0000}) + DIV_NUM_W'(h);
                    div_req.den   = DIV_DEN_W'({h, 1'b0});
                    state_next    = S_WY;
                end
            end
            S_WY:
            begin
                if (div_sts.done)
                begin
                    if (d2 == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = nsq_reg;
                        div_req.den   = d2;
                        state_next    = S_WR;
                    end
                end
            end
            S_WR:
            begin
                if (div_sts.done)
                begin
                    sqrt_req.start = 1'b1;
                    sqrt_req.value = div_quo;
                    state_next     = S_WS;
                end
            end
            S_WS:
            begin
                if (sqrt_sts.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (job_ready)
                begin
                    job_reg  <= job;
                    magx_reg <= (cx >= h) ? (cx - h) : (h - cx);
                    magy_reg <= (cy >= h) ? (cy - h) : (h - cy);
                    negx_reg <= (cx < h);
                    negy_reg <= (cy > h);
                    det_reg  <= job.detected;
                    idx_reg  <= job.slot;
                    ox_reg   <= '0;
                    oy_reg   <= '0;
                    rng_reg  <= '0;
                end
            end
            S_MUL:
            begin
                wsq_reg <= wprod[SQ_W-1:0];
                hsq_reg <= hprod[SQ_W-1:0];
                nsq_reg <= nprod;
            end
            S_WX:
            begin
                if (div_sts.done)
                begin
                    ox_reg <= sat_ofs(negx_reg, div_quo);
                end
            end
            S_WY:
            begin
                if (div_sts.done)
                begin
                    oy_reg <= sat_ofs(negy_reg, div_quo);
                    if (d2 == '0)
                    begin
                        rng_reg <= RANGE_MAX;
                    end
                end
            end
            S_WS:
            begin
                if (sqrt_sts.done)
                begin
                    rng_reg <= RNG_W'(sqrt_root);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: hdl/bbox_target_locator_top.sv
// Top level of the bounding-box target locator: register port, front, queue, back.
// Boxes are taken at one request per cycle unless the queue is full; the argmax register
// updates in that cycle. A detected frame's result takes three 48-step divisions and a
// 24-step root, two divisions with a zero diagonal, none with nothing detected. The
// two-entry job queue takes further frames meanwhile; input stalls only while it is full.
// Reset (rst_n low, async) clears frames, loads 208 and 585.
module bbox_target_locator_top
    import btl_pkg::*;
#(
    parameter int MAX_BOXES   = MAX_BOXES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,

    // box requests
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    box_valid,
    input  logic [COORD_BITS-1:0]   box_xmin,
    input  logic [COORD_BITS-1:0]   box_xmax,
    input  logic [COORD_BITS-1:0]   box_ymin,
    input  logic [COORD_BITS-1:0]   box_ymax,
    input  logic [PROB_W-1:0]       probability,
    input  logic                    last_box,

    // frame results
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    detected,
    output logic [IDX_W-1:0]        chosen_index,
    output logic signed [OFS_W-1:0] offset_x,
    output logic signed [OFS_W-1:0] offset_y,
    output logic [RNG_W-1:0]        range_estimate
);

    logic [HS_W-1:0] hs_reg;
    logic [RC_W-1:0] rc_reg;
    logic            cfg_wr;
    logic            reg_sel;

    logic            in_accept;
    logic            q_push, q_full, q_nonempty, q_pop;
    btl_job_t        q_wdata, q_rdata;

    // register port: zero wait states, word addressed by bit 2
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb
    begin
        unique case (reg_sel)
            REG_HALF_SIZE: prdata = {{(32 - HS_W){1'b0}}, hs_reg};
            REG_RANGE_K:   prdata = {{(32 - RC_W){1'b0}}, rc_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg <= HS_RESET;
            rc_reg <= RC_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_HALF_SIZE: hs_reg <= pwdata[HS_W-1:0];
                REG_RANGE_K:   rc_reg <= pwdata[RC_W-1:0];
                default:       hs_reg <= hs_reg;
            endcase
        end
    end

    // a full queue holds off further requests
    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;

    btl_front #(
        .MAX_BOXES (MAX_BOXES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .box_valid   (box_valid),
        .box_xmin    (box_xmin),
        .box_xmax    (box_xmax),
        .box_ymin    (box_ymin),
        .box_ymax    (box_ymax),
        .probability (probability),
        .last_box    (last_box),
        .push        (q_push),
        .job         (q_wdata)
    );

    btl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wdata    (q_wdata),
        .full     (q_full),
        .nonempty (q_nonempty),
        .pop      (q_pop),
        .rdata    (q_rdata)
    );

    // back end: offsets through the shared divider, range through divider and root
    btl_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .image_half_size (hs_reg),
        .range_constant  (rc_reg),
        .job_ready       (q_nonempty),
        .job             (q_rdata),
        .job_pop         (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .detected        (detected),
        .chosen_index    (chosen_index),
        .offset_x        (offset_x),
        .offset_y        (offset_y),
        .range_estimate  (range_estimate)
    );

    // no frame is pushed into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("job pushed into full queue");

    // a frame without detection carries an all-zero result
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !detected) |->
            (chosen_index == '0 && offset_x == '0 && offset_y == '0 && range_estimate == '0))
        else $error("non-detected result carries data");

    // a taken result is never shown twice
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result repeated after it was taken");

endmodule

// File: test/tb_bbox_target_locator_top.sv
// Self-checking testbench for bbox_target_locator_top: box requests in, frame fixes checked out.
module tb_bbox_target_locator_top
    import btl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles of quiet after the last fix of a phase, to let the back end run dry.
    localparam int SETTLE_CYCLES = 250;
    // No handshake on either channel and no register access for this long means the block has hung.
    localparam int HANG_LIMIT    = 5000;
    localparam int BOX_BUDGET    = 220;

    // One box request as the sender holds it; 'hold_for_idle' makes the sender wait
    // until every fix already owed has come out before offering this request.
    typedef struct {
        logic                  has_box;
        logic [COORD_BITS-1:0] xmin;
        logic [COORD_BITS-1:0] xmax;
        logic [COORD_BITS-1:0] ymin;
        logic [COORD_BITS-1:0] ymax;
        logic [PROB_W-1:0]     prob;
        logic                  last;
        bit                    hold_for_idle;
    } box_req_t;

    // One target fix as the block should report it.
    typedef struct {
        logic                    det;
        logic [IDX_W-1:0]        idx;
        logic signed [OFS_W-1:0] ox;
        logic signed [OFS_W-1:0] oy;
        logic [RNG_W-1:0]        rng;
    } target_fix_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;

    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [2:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    box_valid = 1'b0;
    logic [COORD_BITS-1:0]   box_xmin = '0;
    logic [COORD_BITS-1:0]   box_xmax = '0;
    logic [COORD_BITS-1:0]   box_ymin = '0;
    logic [COORD_BITS-1:0]   box_ymax = '0;
    logic [PROB_W-1:0]       probability = '0;
    logic                    last_box = 1'b0;

    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    detected;
    logic [IDX_W-1:0]        chosen_index;
    logic signed [OFS_W-1:0] offset_x;
    logic signed [OFS_W-1:0] offset_y;
    logic [RNG_W-1:0]        range_estimate;

    bbox_target_locator_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .box_valid      (box_valid),
        .box_xmin       (box_xmin),
        .box_xmax       (box_xmax),
        .box_ymin       (box_ymin),
        .box_ymax       (box_ymax),
        .probability    (probability),
        .last_box       (last_box),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .detected       (detected),
        .chosen_index   (chosen_index),
        .offset_x       (offset_x),
        .offset_y       (offset_y),
        .range_estimate (range_estimate)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    box_req_t    box_backlog[$];   // requests still to be offered to the block
    target_fix_t fixes_due[$];     // fixes owed by the block, oldest first

    int errors        = 0;
    int boxes_seen    = 0;
    int frames_seen   = 0;
    int fixes_checked = 0;
    int settings_run  = 1;

    // Register copies as the block should hold them after reset.
    logic [HS_W-1:0] hs_cfg = HS_RESET;
    logic [RC_W-1:0] rc_cfg = RC_RESET;

    // Frame tracking: the strongest box so far and how many boxes have counted.
    logic [PROB_W-1:0]     best_p   = '0;
    logic [COORD_BITS-1:0] best_l   = '0;
    logic [COORD_BITS-1:0] best_r   = '0;
    logic [COORD_BITS-1:0] best_t   = '0;
    logic [COORD_BITS-1:0] best_b   = '0;
    logic [IDX_W-1:0]      best_idx = '0;
    int                    frame_boxes = 0;

    function automatic void check_field(string what, longint want, longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    // Largest r with r*r <= v, by bisection; v stays below 2^48 here.
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << 25;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // p/h as Q1.15: round half away from zero, then clamp to the 16-bit range.
    function automatic logic [OFS_W-1:0] to_q15(longint p, longint h);
        longint mag;
        longint q;
        mag = (p < 0) ? -p : p;
        q = ((mag << 16) + h) / (2 * h);
        if (p < 0)
            return (q > 32768) ? 16'h8000 : OFS_W'(-q);
        return (q > 32767) ? 16'h7FFF : OFS_W'(q);
    endfunction

    // The fix for the frame just closed, from the tracked best box and the registers.
    function automatic target_fix_t locate_target();
        target_fix_t     f;
        longint          h;
        longint          l;
        longint          r;
        longint          t;
        longint          b;
        longint          w;
        longint          hh;
        longint unsigned d2;
        longint unsigned num;
        longint unsigned rng;
        f.det = 1'b0;
        f.idx = '0;
        f.ox  = '0;
        f.oy  = '0;
        f.rng = '0;
        if (best_p == 0)
            return f;
        h = (hs_cfg == 0) ? 1 : hs_cfg;
        l = best_l;
        r = best_r;
        t = best_t;
        b = best_b;
        w  = r - l;
        hh = b - t;
        d2 = w * w + hh * hh;
        if (d2 == 0)
            rng = RANGE_MAX;
        else
        begin
            num = rc_cfg;
            num = num << 8;
            rng = root_floor((num * num) / d2);
            if (rng > RANGE_MAX)
                rng = RANGE_MAX;
        end
        f.det = 1'b1;
        f.idx = best_idx;
        f.ox  = to_q15(((l + r) >> 1) - h, h);
        // image rows grow downward, so the vertical offset is negated
        f.oy  = to_q15(h - ((t + b) >> 1), h);
        f.rng = RNG_W'(rng);
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Monitor and predictor, both on the rising edge. Results are checked
    // first; a box request taken on the same edge then updates the frame.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        target_fix_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (fixes_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: fix with none expected, expected nothing, actual det=%0d idx=%0d",
                             $time, detected, chosen_index);
                end
                else
                begin
                    want = fixes_due.pop_front();
                    check_field("detected", want.det, detected);
                    check_field("chosen_index", want.idx, chosen_index);
                    check_field("offset_x", want.ox, offset_x);
                    check_field("offset_y", want.oy, offset_y);
                    check_field("range_estimate", want.rng, range_estimate);
                    fixes_checked++;
                end
            end

            if (in_valid && !in_stall)
            begin
                if (box_valid)
                    boxes_seen++;
                // boxes past the frame capacity neither count nor compete
                if (box_valid && frame_boxes < MAX_BOXES_DEF)
                begin
                    if (probability > best_p)
                    begin
                        best_p   = probability;
                        best_l   = box_xmin;
                        best_r   = box_xmax;
                        best_t   = box_ymin;
                        best_b   = box_ymax;
                        best_idx = IDX_W'(frame_boxes);
                    end
                    frame_boxes++;
                end
                if (last_box)
                begin
                    fixes_due.push_back(locate_target());
                    frames_seen++;
                    best_p      = '0;
                    best_l      = '0;
                    best_r      = '0;
                    best_t      = '0;
                    best_b      = '0;
                    best_idx    = '0;
                    frame_boxes = 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Box sender: bursts of random length with random gaps, driven on the
    // falling edge. A request stays put until the edge that takes it.
    // ------------------------------------------------------------------
    logic     req_taken = 1'b0;
    int       burst_left = 1;
    int       gap_left = 0;
    box_req_t next_req;

    always @(posedge clk)
        req_taken <= in_valid && !in_stall;

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !req_taken)
        begin
            // stalled: hold the request
        end
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left--;
        end
        else if (box_backlog.size() == 0 ||
                 (box_backlog[0].hold_for_idle && fixes_due.size() != 0))
            in_valid <= 1'b0;
        else
        begin
            next_req    = box_backlog.pop_front();
            box_valid   <= next_req.has_box;
            box_xmin    <= next_req.xmin;
            box_xmax    <= next_req.xmax;
            box_ymin    <= next_req.ymin;
            box_ymax    <= next_req.ymax;
            probability <= next_req.prob;
            last_box    <= next_req.last;
            in_valid    <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left = $urandom_range(1, 40);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: gap_left = 0;
                    9:             gap_left = $urandom_range(10, 40);
                    default:       gap_left = $urandom_range(1, 8);
                endcase
            end
            else
                burst_left--;
        end
    end

    // ------------------------------------------------------------------
    // Fix receiver: stall pattern that switches style at random times - never, sparse random,
    // mostly stalled, or a fixed duty cycle.
    // ------------------------------------------------------------------
    int stall_style = 0;
    int stall_span  = 0;

    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_span  = $urandom_range(50, 300);
        end
        else
            stall_span--;
        case (stall_style)
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            2:       out_stall <= ($urandom_range(0, 7) != 0);
            3:       out_stall <= ((stall_span % 16) < 11);
            default: out_stall <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Hang detector: any handshake or register access counts as progress.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("bbox_target_locator_top verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_box(bit has, int xa, int xb, int ya, int yb, int p, bit fin,
                            bit hold);
        box_req_t b;
        b.has_box       = has;
        b.xmin          = COORD_BITS'(xa);
        b.xmax          = COORD_BITS'(xb);
        b.ymin          = COORD_BITS'(ya);
        b.ymax          = COORD_BITS'(yb);
        b.prob          = PROB_W'(p);
        b.last          = fin;
        b.hold_for_idle = hold;
        box_backlog.push_back(b);
    endtask

    // A box: anywhere on the coordinate range, inside the image, or degenerate.
    function automatic box_req_t random_box(int span);
        box_req_t b;
        int       pick;
        b.has_box       = 1'b1;
        b.last          = 1'b0;
        b.hold_for_idle = 1'b0;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            b.xmin = COORD_BITS'($urandom);
            b.xmax = COORD_BITS'($urandom);
            b.ymin = COORD_BITS'($urandom);
            b.ymax = COORD_BITS'($urandom);
        end
        else if (pick < 9)
        begin
            b.xmin = COORD_BITS'($urandom_range(0, span));
            b.xmax = COORD_BITS'($urandom_range(b.xmin, span));
            b.ymin = COORD_BITS'($urandom_range(0, span));
            b.ymax = COORD_BITS'($urandom_range(b.ymin, span));
        end
        else
        begin
            // zero-size or inverted box
            b.xmin = COORD_BITS'($urandom);
            b.ymin = COORD_BITS'($urandom);
            b.xmax = $urandom_range(0, 1) ? b.xmin : COORD_BITS'($urandom_range(0, b.xmin));
            b.ymax = $urandom_range(0, 1) ? b.ymin : COORD_BITS'($urandom_range(0, b.ymin));
        end
        case ($urandom_range(0, 9))
            0, 1:    b.prob = '0;
            2:       b.prob = '1;
            3, 4:    b.prob = PROB_W'($urandom_range(1, 3));   // ties likely
            default: b.prob = PROB_W'($urandom);
        endcase
        return b;
    endfunction

    // One frame of n boxes with the odd ignored no-box request mixed in.
    // Oversize frames put the strongest boxes past the frame capacity.
    task automatic queue_one_frame(int n, bit hold, bit oversize);
        box_req_t b;
        int       i;
        int       span;
        bit       marker_end;
        span = hs_cfg;
        span = (span == 0) ? 2 : 2 * span;
        if (span > 4095)
            span = 4095;
        marker_end = (n == 0) || ($urandom_range(0, 19) == 0);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                b = random_box(span);
                b.has_box       = 1'b0;
                b.hold_for_idle = hold;
                hold            = 1'b0;
                box_backlog.push_back(b);
            end
            b = random_box(span);
            if (oversize)
                b.prob = (i >= MAX_BOXES_DEF) ? PROB_W'(16'hFFFF)
                                              : PROB_W'($urandom_range(1, 60000));
            b.last          = (i == n - 1) && !marker_end;
            b.hold_for_idle = hold;
            hold            = 1'b0;
            box_backlog.push_back(b);
        end
        if (marker_end)
        begin
            b = random_box(span);
            b.has_box       = 1'b0;
            b.last          = 1'b1;
            b.hold_for_idle = hold;
            box_backlog.push_back(b);
        end
    endtask

    // Frames of mostly short length until about 'budget' boxes are queued.
    task automatic queue_frames(int budget, bit with_oversize);
        int made;
        int n;
        int r;
        int fno;
        made = 0;
        fno  = 0;
        while (made < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                n = 0;
            else if (r < 15)
                n = 1;
            else if (r < 70)
                n = $urandom_range(2, 8);
            else if (r < 95)
                n = $urandom_range(9, 30);
            else
                n = $urandom_range(31, 80);
            // every tenth frame waits for the block to empty before it starts
            queue_one_frame(n, (fno % 10) == 3, 1'b0);
            made += n;
            fno++;
        end
        if (with_oversize)
            queue_one_frame(MAX_BOXES_DEF + 44, 1'b1, 1'b1);
    endtask

    // Wait until every request is taken and every fix is out, then let the
    // back end run dry before anything touches the registers.
    task automatic settle();
        while (box_backlog.size() != 0 || in_valid || fixes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write (setup then access), then a read back of the same register.
    task automatic write_reg(logic reg_sel, logic [31:0] value);
        logic [31:0] got;
        logic [31:0] mask;
        mask = (reg_sel == REG_HALF_SIZE) ? 32'((1 << HS_W) - 1) : 32'((1 << RC_W) - 1);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == REG_HALF_SIZE)
            hs_cfg = value[HS_W-1:0];
        else
            rc_cfg = value[RC_W-1:0];
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("register read back", value & mask, got & mask);
    endtask

    // ------------------------------------------------------------------
    // Test sequence: directed and random frames on the reset settings, then random
    // frames under five further register settings, extremes included.
    // ------------------------------------------------------------------
    initial
    begin
        int          ph;
        logic [31:0] hs_set[1:5];
        logic [31:0] rc_set[1:5];

        hs_set[1] = 1;
        rc_set[1] = 1;
        hs_set[2] = 4095;
        rc_set[2] = 65535;
        hs_set[3] = 0;       // treated as a half size of one
        rc_set[3] = 0;
        hs_set[4] = 2048;
        rc_set[4] = $urandom_range(1, 65535);
        hs_set[5] = $urandom_range(1, 4095);
        rc_set[5] = $urandom_range(1, 65535);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty frame: a lone no-box request closing it
        push_box(0, 0, 0, 0, 0, 0, 1, 0);
        // every box at zero probability: nothing detected
        push_box(1, 10, 20, 30, 40, 0, 0, 0);
        push_box(1, 4095, 4095, 4095, 4095, 0, 1, 0);
        // box spanning the full coordinate range: both offsets clamp
        push_box(1, 0, 4095, 0, 4095, 65535, 1, 0);
        // equal probabilities: the first box keeps the lead
        push_box(1, 100, 150, 50, 90, 100, 0, 0);
        push_box(1, 300, 400, 300, 400, 100, 0, 0);
        push_box(1, 0, 10, 0, 10, 50, 1, 0);
        // rising probabilities, the last box (inverted, at the far corner) wins
        push_box(1, 0, 0, 4095, 4095, 1, 0, 0);
        push_box(1, 200, 216, 200, 216, 2, 0, 0);
        push_box(1, 4095, 0, 4095, 0, 65535, 1, 0);
        // zero diagonal at the image centre: range clamps high, offsets zero
        push_box(1, 208, 208, 208, 208, 5, 1, 0);
        // inverted box: negative width and height
        push_box(1, 4095, 0, 300, 10, 7, 1, 0);
        // a no-box request with top probability must not compete or count
        push_box(1, 50, 60, 70, 80, 10, 0, 0);
        push_box(0, 1, 2, 3, 4, 65535, 0, 0);
        push_box(1, 400, 416, 0, 4095, 20, 1, 0);
        // frame closed by a no-box request
        push_box(1, 0, 4095, 4095, 0, 1, 0, 0);
        push_box(0, 4095, 4095, 4095, 4095, 65535, 1, 0);
        // one-pixel box just off centre, sent only once the block is idle
        push_box(1, 207, 208, 209, 209, 40000, 1, 1);

        queue_frames(BOX_BUDGET, 1'b0);
        settle();

        for (ph = 1; ph <= 5; ph++)
        begin
            write_reg(REG_HALF_SIZE, hs_set[ph]);
            write_reg(REG_RANGE_K, rc_set[ph]);
            settings_run++;
            queue_frames(BOX_BUDGET, ph == 2);
            settle();
        end

        $display("Ran %0d boxes in %0d frames across %0d register settings.",
                 boxes_seen, frames_seen, settings_run);
        $display("Checked %0d target fixes, %0d mismatches.", fixes_checked, errors);
        if (errors == 0)
            $display("bbox_target_locator_top verification clean");
        else
            $display("bbox_target_locator_top verification failed");
        $finish;
    end

endmodule
